[hdl/lss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lss_pkg;

    localparam int TIMEOUT_WIDTH_DEF = 16;
    localparam int RETRY_WIDTH_DEF   = 4;

    localparam int NUM_STATES  = 13;
    localparam int NUM_EVENTS  = 22;
    localparam int TO_FIELD_W  = 16;
    localparam int LIM_FIELD_W = 4;
    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;

    typedef logic [3:0] state_code_t;
    typedef logic [4:0] event_code_t;
    typedef logic [1:0] cmd_code_t;
    typedef logic [1:0] status_code_t;
    typedef logic [2:0] reg_idx_t;

    localparam state_code_t ST_DISCONNECTED  = 4'd0;
    localparam state_code_t ST_CONNECTING    = 4'd1;
    localparam state_code_t ST_ADAPTER_INIT  = 4'd2;
    localparam state_code_t ST_PROTO_DETECT  = 4'd3;
    localparam state_code_t ST_HANDSHAKE     = 4'd4;
    localparam state_code_t ST_IDLE          = 4'd5;
    localparam state_code_t ST_READING_PIDS  = 4'd6;
    localparam state_code_t ST_READING_DTCS  = 4'd7;
    localparam state_code_t ST_CLEARING_DTCS = 4'd8;
    localparam state_code_t ST_READING_FRAME = 4'd9;
    localparam state_code_t ST_READING_INFO  = 4'd10;
    localparam state_code_t ST_ERROR         = 4'd11;
    localparam state_code_t ST_RECOVERY      = 4'd12;

    localparam event_code_t EV_NONE            = 5'd0;
    localparam event_code_t EV_CONNECT_REQ     = 5'd1;
    localparam event_code_t EV_DISCONNECT_REQ  = 5'd2;
    localparam event_code_t EV_CONNECTED       = 5'd3;
    localparam event_code_t EV_DISCONNECTED    = 5'd4;
    localparam event_code_t EV_INIT_DONE       = 5'd5;
    localparam event_code_t EV_INIT_FAILED     = 5'd6;
    localparam event_code_t EV_PROTO_FOUND     = 5'd7;
    localparam event_code_t EV_PROTO_FAILED    = 5'd8;
    localparam event_code_t EV_HANDSHAKE_DONE  = 5'd9;
    localparam event_code_t EV_HANDSHAKE_FAIL  = 5'd10;
    localparam event_code_t EV_READ_PIDS       = 5'd11;
    localparam event_code_t EV_READ_DTCS       = 5'd12;
    localparam event_code_t EV_CLEAR_DTCS      = 5'd13;
    localparam event_code_t EV_READ_FRAME      = 5'd14;
    localparam event_code_t EV_READ_INFO       = 5'd15;
    localparam event_code_t EV_OP_DONE         = 5'd16;
    localparam event_code_t EV_OP_FAILED       = 5'd17;
    localparam event_code_t EV_TIMEOUT         = 5'd18;
    localparam event_code_t EV_ERROR           = 5'd19;
    localparam event_code_t EV_RECOVERY_DONE   = 5'd20;
    localparam event_code_t EV_RECOVERY_FAILED = 5'd21;

    localparam cmd_code_t CMD_EVENT      = 2'd0;
    localparam cmd_code_t CMD_TICK       = 2'd1;
    localparam cmd_code_t CMD_DISCONNECT = 2'd2;

    localparam status_code_t STATUS_OK        = 2'd0;
    localparam status_code_t STATUS_NO_ARC    = 2'd1;
    localparam status_code_t STATUS_BAD_EVENT = 2'd2;

    localparam reg_idx_t REG_TO_S0_S2  = 3'd0;
    localparam reg_idx_t REG_TO_S3_S5  = 3'd1;
    localparam reg_idx_t REG_TO_S6_S8  = 3'd2;
    localparam reg_idx_t REG_TO_S9_S11 = 3'd3;
    localparam reg_idx_t REG_TO_S12    = 3'd4;
    localparam reg_idx_t REG_LIMITS    = 3'd5;

    typedef struct packed {
        logic [NUM_STATES-1:0][TO_FIELD_W-1:0]  timeout;
        logic [NUM_STATES-1:0][LIM_FIELD_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic        hit;
        state_code_t next;
    } arc_t;

    function automatic arc_t arc_lookup(state_code_t s, event_code_t ev);
        arc_t r;
        r.hit  = 1'b1;
        r.next = ST_DISCONNECTED;
        case (s) inside
            ST_DISCONNECTED:
            begin
                case (ev)
                    EV_CONNECT_REQ: r.next = ST_CONNECTING;
                    default:        r.hit  = 1'b0;
                endcase
            end
            ST_CONNECTING:
            begin
                case (ev)
                    EV_CONNECTED:      r.next = ST_ADAPTER_INIT;
                    EV_TIMEOUT:        r.next = ST_ERROR;
                    EV_ERROR:          r.next = ST_ERROR;
                    EV_DISCONNECT_REQ: r.next = ST_DISCONNECTED;
                    default:           r.hit  = 1'b0;
                endcase
            end
            ST_ADAPTER_INIT:
            begin
                case (ev)
                    EV_INIT_DONE:      r.next = ST_PROTO_DETECT;
                    EV_INIT_FAILED:    r.next = ST_RECOVERY;
                    EV_TIMEOUT:        r.next = ST_RECOVERY;
                    EV_DISCONNECT_REQ: r.next = ST_DISCONNECTED;
                    default:           r.hit  = 1'b0;
                endcase
            end
            ST_PROTO_DETECT:
            begin
                case (ev)
                    EV_PROTO_FOUND:    r.next = ST_HANDSHAKE;
                    EV_PROTO_FAILED:   r.next = ST_RECOVERY;
                    EV_TIMEOUT:        r.next = ST_RECOVERY;
                    EV_DISCONNECT_REQ: r.next = ST_DISCONNECTED;
                    default:           r.hit  = 1'b0;
                endcase
            end
            ST_HANDSHAKE:
            begin
                case (ev)
                    EV_HANDSHAKE_DONE: r.next = ST_IDLE;
                    EV_HANDSHAKE_FAIL: r.next = ST_RECOVERY;
                    EV_TIMEOUT:        r.next = ST_RECOVERY;
                    EV_DISCONNECT_REQ: r.next = ST_DISCONNECTED;
                    default:           r.hit  = 1'b0;
                endcase
            end
            ST_IDLE:
            begin
                case (ev)
                    EV_READ_PIDS:      r.next = ST_READING_PIDS;
                    EV_READ_DTCS:      r.next = ST_READING_DTCS;
                    EV_CLEAR_DTCS:     r.next = ST_CLEARING_DTCS;
                    EV_READ_FRAME:     r.next = ST_READING_FRAME;
                    EV_READ_INFO:      r.next = ST_READING_INFO;
                    EV_DISCONNECT_REQ: r.next = ST_DISCONNECTED;
                    EV_ERROR:          r.next = ST_ERROR;
                    default:           r.hit  = 1'b0;
                endcase
            end
            [ST_READING_PIDS:ST_READING_INFO]:
            begin
                case (ev)
                    EV_OP_DONE:        r.next = ST_IDLE;
                    EV_OP_FAILED:      r.next = ST_RECOVERY;
                    EV_TIMEOUT:        r.next = ST_RECOVERY;
                    EV_DISCONNECT_REQ: r.next = ST_DISCONNECTED;
                    default:           r.hit  = 1'b0;
                endcase
            end
            ST_ERROR:
            begin
                case (ev)
                    EV_RECOVERY_DONE:  r.next = ST_IDLE;
                    EV_DISCONNECT_REQ: r.next = ST_DISCONNECTED;
                    default:           r.hit  = 1'b0;
                endcase
            end
            ST_RECOVERY:
            begin
                case (ev)
                    EV_RECOVERY_DONE:   r.next = ST_ADAPTER_INIT;
                    EV_RECOVERY_FAILED: r.next = ST_ERROR;
                    EV_TIMEOUT:         r.next = ST_ERROR;
                    EV_DISCONNECT_REQ:  r.next = ST_DISCONNECTED;
                    default:            r.hit  = 1'b0;
                endcase
            end
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/lss_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module lss_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lss_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lss_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lss_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output lss_pkg::cfg_t                      cfg
);

    logic [lss_pkg::NUM_STATES-1:0][lss_pkg::TO_FIELD_W-1:0]  timeout_reg;
    logic [lss_pkg::NUM_STATES-1:0][lss_pkg::LIM_FIELD_W-1:0] limit_reg;
    lss_pkg::reg_idx_t                                        idx;
    logic                                                     wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[5:3];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= '0;
            limit_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                lss_pkg::REG_TO_S0_S2:  timeout_reg[2:0]   <= pwdata[47:0];
                lss_pkg::REG_TO_S3_S5:  timeout_reg[5:3]   <= pwdata[47:0];
                lss_pkg::REG_TO_S6_S8:  timeout_reg[8:6]   <= pwdata[47:0];
                lss_pkg::REG_TO_S9_S11: timeout_reg[11:9]  <= pwdata[47:0];
                lss_pkg::REG_TO_S12:    timeout_reg[12]    <= pwdata[15:0];
                lss_pkg::REG_LIMITS:    limit_reg          <= pwdata[51:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            lss_pkg::REG_TO_S0_S2:  prdata = 64'(timeout_reg[2:0]);
            lss_pkg::REG_TO_S3_S5:  prdata = 64'(timeout_reg[5:3]);
            lss_pkg::REG_TO_S6_S8:  prdata = 64'(timeout_reg[8:6]);
            lss_pkg::REG_TO_S9_S11: prdata = 64'(timeout_reg[11:9]);
            lss_pkg::REG_TO_S12:    prdata = 64'(timeout_reg[12]);
            lss_pkg::REG_LIMITS:    prdata = 64'(limit_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.timeout = timeout_reg;
    assign cfg.limit   = limit_reg;

endmodule

`default_nettype wire

[hdl/link_session_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none

// session sequencer over 13 states and a fixed table of 50 arcs. each input beat carries a
// command in tuser (event, 1 ms tick, forced disconnect) and an event code in tdata; each beat
// gives exactly one result beat with status in tuser and the state summary in tdata. one beat
// is taken every clock unless the result output stalls; each beat passes through the input
// register, then table lookup, timeout compare and state update into the result register.
// the rate is set by the state update loop. per-state timeouts and retry limits sit in the apb
// port at 8-byte spacing; the user must write them only while the stream is idle (not enforced).
module link_session_sequencer
#(
    parameter int TIMEOUT_WIDTH = lss_pkg::TIMEOUT_WIDTH_DEF,
    parameter int RETRY_WIDTH   = lss_pkg::RETRY_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // event_code[4:0], zero pad
    input  logic [1:0]                     s_axis_tuser,   // cmd[1:0]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // state_now[3:0], state_before[7:4], changed[8], cause_event[13:9], retries_used[17:14]
    output logic [23:0]                    m_axis_tdata,
    output logic [1:0]                     m_axis_tuser,   // status[1:0]
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lss_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lss_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int CMP_W = (TIMEOUT_WIDTH > lss_pkg::TO_FIELD_W) ? TIMEOUT_WIDTH
                                                                  : lss_pkg::TO_FIELD_W;
    localparam int LIM_W = (RETRY_WIDTH > lss_pkg::LIM_FIELD_W) ? RETRY_WIDTH
                                                                 : lss_pkg::LIM_FIELD_W;
    localparam logic [LIM_W-1:0] RETRY_MAX = LIM_W'((1 << RETRY_WIDTH) - 1);

    lss_pkg::cfg_t cfg;

    lss_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input stage
    logic                  in_valid_reg;
    lss_pkg::cmd_code_t    in_cmd_reg;
    lss_pkg::event_code_t  in_event_reg;
    logic                  advance;
    logic                  step;

    // session state
    lss_pkg::state_code_t     cur_state_reg, cur_state_next;
    lss_pkg::state_code_t     prior_state_reg, prior_state_next;
    logic [RETRY_WIDTH-1:0]   retry_reg, retry_next;
    logic [TIMEOUT_WIDTH-1:0] elapsed_reg, elapsed_next;

    // result stage
    logic                   out_valid_reg;
    lss_pkg::status_code_t  status_reg, status_next;
    lss_pkg::state_code_t   now_reg;
    lss_pkg::state_code_t   before_reg;
    logic                   changed_reg, changed_next;
    lss_pkg::event_code_t   cause_reg, cause_next;
    logic [3:0]             retries_out_reg;

    // datapath
    logic [TIMEOUT_WIDTH-1:0]        elapsed_inc;
    logic [lss_pkg::TO_FIELD_W-1:0]  tmo;
    logic [LIM_W-1:0]                lim_ext;
    logic [RETRY_WIDTH-1:0]          lim;
    logic [LIM_W-1:0]                retry_ext;
    lss_pkg::arc_t                   ev_arc;
    lss_pkg::arc_t                   tmo_arc;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign step          = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg   <= s_axis_tuser;
            in_event_reg <= s_axis_tdata[4:0];
        end
    end

    always_comb
    begin
        if (cur_state_reg < 4'(lss_pkg::NUM_STATES))
        begin
            tmo     = cfg.timeout[cur_state_reg];
            lim_ext = LIM_W'(cfg.limit[cur_state_reg]);
        end
        else
        begin
            tmo     = '0;
            lim_ext = '0;
        end
    end

    // limit clipped to what the retry counter can hold
    assign lim         = RETRY_WIDTH'((lim_ext > RETRY_MAX) ? RETRY_MAX : lim_ext);
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign ev_arc      = lss_pkg::arc_lookup(cur_state_reg, in_event_reg);
    assign tmo_arc     = lss_pkg::arc_lookup(cur_state_reg, lss_pkg::EV_TIMEOUT);

    always_comb
    begin
        cur_state_next   = cur_state_reg;
        prior_state_next = prior_state_reg;
        retry_next       = retry_reg;
        elapsed_next     = elapsed_reg;
        status_next      = lss_pkg::STATUS_OK;
        changed_next     = 1'b0;
        cause_next       = lss_pkg::EV_NONE;
        case (in_cmd_reg)
            lss_pkg::CMD_EVENT:
            begin
                if (in_event_reg >= 5'(lss_pkg::NUM_EVENTS))
                begin
                    status_next = lss_pkg::STATUS_BAD_EVENT;
                end
                else if (in_event_reg != lss_pkg::EV_NONE)
                begin
                    if (ev_arc.hit)
                    begin
                        prior_state_next = cur_state_reg;
                        cur_state_next   = ev_arc.next;
                        retry_next       = '0;
                        elapsed_next     = '0;
                        changed_next     = 1'b1;
                        cause_next       = in_event_reg;
                    end
                    else
                    begin
                        status_next = lss_pkg::STATUS_NO_ARC;
                    end
                end
            end
            lss_pkg::CMD_TICK:
            begin
                elapsed_next = elapsed_inc;
                if ((tmo != '0) && (CMP_W'(elapsed_inc) >= CMP_W'(tmo)))
                begin
                    if (retry_reg < lim)
                    begin
                        retry_next   = retry_reg + 1'b1;
                        elapsed_next = '0;
                    end
                    else if (tmo_arc.hit)
                    begin
                        prior_state_next = cur_state_reg;
                        cur_state_next   = tmo_arc.next;
                        retry_next       = '0;
                        elapsed_next     = '0;
                        changed_next     = 1'b1;
                        cause_next       = lss_pkg::EV_TIMEOUT;
                    end
                    else
                    begin
                        status_next = lss_pkg::STATUS_NO_ARC;
                    end
                end
            end
            lss_pkg::CMD_DISCONNECT:
            begin
                prior_state_next = cur_state_reg;
                cur_state_next   = lss_pkg::ST_DISCONNECTED;
                retry_next       = '0;
                elapsed_next     = '0;
                changed_next     = 1'b1;
                cause_next       = lss_pkg::EV_DISCONNECT_REQ;
            end
            default:
            begin
            end
        endcase
    end

    assign retry_ext = LIM_W'(retry_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg   <= lss_pkg::ST_DISCONNECTED;
            prior_state_reg <= lss_pkg::ST_DISCONNECTED;
            retry_reg       <= '0;
            elapsed_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                cur_state_reg   <= cur_state_next;
                prior_state_reg <= prior_state_next;
                retry_reg       <= retry_next;
                elapsed_reg     <= elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            status_reg      <= status_next;
            now_reg         <= cur_state_next;
            before_reg      <= prior_state_next;
            changed_reg     <= changed_next;
            cause_reg       <= cause_next;
            retries_out_reg <= retry_ext[3:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {6'd0, retries_out_reg, cause_reg, changed_reg, before_reg, now_reg};

`ifndef NO_ASSERTIONS
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_state_reg <= 4'(lss_pkg::NUM_STATES - 1))
        else $error("session state out of range");

    a_change_clears_retries: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && changed_reg) |-> (retries_out_reg == 4'd0))
        else $error("retry count not cleared on a transition");

    a_bad_event_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == lss_pkg::STATUS_BAD_EVENT)) |-> !changed_reg)
        else $error("invalid event made a transition");

    a_step_updates_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (out_valid_reg && (now_reg == cur_state_reg)))
        else $error("result state differs from session state");
`endif

endmodule

`default_nettype wire
